// ===== hw/rtl/arfm_pkg.sv =====
// ----------------------------------------------------------------------------
// arfm_pkg
// Shared types and constants of the audio ring FIFO and tone mixer.
// ----------------------------------------------------------------------------
package arfm_pkg;

	localparam int FIFO_FRAMES = 32768;
	localparam int PTR_W       = (FIFO_FRAMES > 1) ? $clog2(FIFO_FRAMES) : 1;
	localparam int CNT_W       = $clog2(FIFO_FRAMES + 1);
	localparam int SAMPLE_W    = 16;
	localparam int FRAME_W     = 2 * SAMPLE_W;
	localparam int FILL_W      = 16;
	localparam int PHASE_W     = 32;
	localparam int PHASE_MSB   = PHASE_W - 1;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	localparam logic signed [SAMPLE_W-1:0] TONE_AMP = 16'sd8000;
	localparam logic signed [SAMPLE_W-1:0] SAT_MAX  = 16'sh7fff;
	localparam logic signed [SAMPLE_W-1:0] SAT_MIN  = 16'sh8000;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_DISABLED = 2'd2,
		ST_UNDERRUN = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PLAYBACK_ENABLE = 2'd0,
		REG_TONE_ENABLE     = 2'd1,
		REG_TONE_STEP       = 2'd2
	} reg_index_t;

	typedef enum logic {
		KIND_PUSH = 1'b0,
		KIND_PULL = 1'b1
	} kind_t;

	typedef struct packed {
		logic use_sample;
		logic mix;
		logic tone_pos;
	} lane_ctrl_t;

endpackage

// ===== hw/rtl/arfm_if.sv =====
// ----------------------------------------------------------------------------
// arfm_req_if / arfm_rsp_if
// Valid/ready channels for requests into the mixer and results out of it.
// ----------------------------------------------------------------------------
interface arfm_req_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   kind;
	logic signed [arfm_pkg::SAMPLE_W-1:0]   left_sample;
	logic signed [arfm_pkg::SAMPLE_W-1:0]   right_sample;

	modport source (output valid, kind, left_sample, right_sample, input ready);
	modport sink (input valid, kind, left_sample, right_sample, output ready);
endinterface

interface arfm_rsp_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [arfm_pkg::SAMPLE_W-1:0]   left_out;
	logic signed [arfm_pkg::SAMPLE_W-1:0]   right_out;
	logic [1:0]                             status;
	logic [arfm_pkg::FILL_W-1:0]            fill_level;

	modport source (output valid, left_out, right_out, status, fill_level, input ready);
	modport sink (input valid, left_out, right_out, status, fill_level, output ready);
endinterface

// ===== hw/rtl/arfm_ram.sv =====
// ----------------------------------------------------------------------------
// arfm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module arfm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/arfm_lane.sv =====
// ----------------------------------------------------------------------------
// arfm_lane
// One channel of the mixer: selects the stored sample or silence and, when
// mixing, adds the square tone with saturation to the signed 16-bit range.
// ----------------------------------------------------------------------------
module arfm_lane (
	input  arfm_pkg::lane_ctrl_t                  ctrl,
	input  logic signed [arfm_pkg::SAMPLE_W-1:0]  sample,
	output logic signed [arfm_pkg::SAMPLE_W-1:0]  mixed
);

	logic signed [arfm_pkg::SAMPLE_W-1:0] base;
	logic signed [arfm_pkg::SAMPLE_W-1:0] tone;
	logic        [arfm_pkg::SAMPLE_W:0]   sum;

	always_comb begin
		base = ctrl.use_sample ? sample : '0;
		tone = ctrl.tone_pos ? arfm_pkg::TONE_AMP : -arfm_pkg::TONE_AMP;
		sum  = {base[arfm_pkg::SAMPLE_W-1], base} + {tone[arfm_pkg::SAMPLE_W-1], tone};
		if (!ctrl.mix) begin
			mixed = base;
		end else if (sum[arfm_pkg::SAMPLE_W] != sum[arfm_pkg::SAMPLE_W-1]) begin
			mixed = sum[arfm_pkg::SAMPLE_W] ? arfm_pkg::SAT_MIN : arfm_pkg::SAT_MAX;
		end else begin
			mixed = sum[arfm_pkg::SAMPLE_W-1:0];
		end
	end

endmodule

// ===== hw/rtl/audio_ring_fifo_tone_mixer_top.sv =====
// ----------------------------------------------------------------------------
// audio_ring_fifo_tone_mixer_top
// Stage 1 registers the request and RAM read; stage 2 registers the result.
// Throughput: one request per cycle; a push uses the frame RAM write port and
// a pull its read port, and requests stall only while both stages are held.
// Reset clears pointers, fill count, phase and registers at once; there is no
// clearing pass, and frame RAM contents stay undefined until written.
// ----------------------------------------------------------------------------
module audio_ring_fifo_tone_mixer_top (
	input  logic                                clk,
	input  logic                                arst_n,
	arfm_req_if.sink                            req,
	arfm_rsp_if.source                          rsp,
	input  logic                                cfg_we,
	input  logic [arfm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [arfm_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic                               playback_en_q;
	logic                               tone_en_q;
	logic [arfm_pkg::PHASE_W-1:0]       tone_step_q;
	logic [arfm_pkg::PHASE_W-1:0]       phase_q;
	logic [arfm_pkg::PTR_W-1:0]         rd_ptr_q;
	logic [arfm_pkg::PTR_W-1:0]         wr_ptr_q;
	logic [arfm_pkg::CNT_W-1:0]         count_q;

	logic                               accept;
	logic                               is_pull;
	logic                               push_ok;
	logic                               pull_ok;
	logic                               mix_now;
	logic [arfm_pkg::PHASE_W-1:0]       phase_next;
	logic [arfm_pkg::CNT_W-1:0]         count_next;
	arfm_pkg::status_t                  status_now;
	logic [arfm_pkg::FRAME_W-1:0]       rdata;

	logic                               valid_s1;
	arfm_pkg::status_t                  status_s1;
	logic [arfm_pkg::FILL_W-1:0]        fill_s1;
	arfm_pkg::lane_ctrl_t               ctrl_s1;
	logic                               advance_s1;

	logic                               valid_s2;
	logic signed [arfm_pkg::SAMPLE_W-1:0] left_s2;
	logic signed [arfm_pkg::SAMPLE_W-1:0] right_s2;
	arfm_pkg::status_t                  status_s2;
	logic [arfm_pkg::FILL_W-1:0]        fill_s2;

	logic signed [arfm_pkg::SAMPLE_W-1:0] left_mix;
	logic signed [arfm_pkg::SAMPLE_W-1:0] right_mix;

	assign advance_s1 = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready  = !valid_s1 || advance_s1;
	assign accept     = req.valid && req.ready;

	always_comb begin
		is_pull    = (req.kind == arfm_pkg::KIND_PULL);
		push_ok    = !is_pull && playback_en_q &&
			(count_q != arfm_pkg::CNT_W'(arfm_pkg::FIFO_FRAMES));
		pull_ok    = is_pull && (count_q != '0);
		mix_now    = is_pull && tone_en_q;
		phase_next = phase_q + tone_step_q;
		count_next = count_q;
		if (push_ok) begin
			count_next = count_q + 1'b1;
		end else if (pull_ok) begin
			count_next = count_q - 1'b1;
		end
		if (is_pull) begin
			status_now = pull_ok ? arfm_pkg::ST_OK : arfm_pkg::ST_UNDERRUN;
		end else if (!playback_en_q) begin
			status_now = arfm_pkg::ST_DISABLED;
		end else if (!push_ok) begin
			status_now = arfm_pkg::ST_FULL;
		end else begin
			status_now = arfm_pkg::ST_OK;
		end
	end

	arfm_ram #(
		.WIDTH (arfm_pkg::FRAME_W),
		.DEPTH (arfm_pkg::FIFO_FRAMES)
	) u_frame_ram (
		.clk   (clk),
		.we    (accept && push_ok),
		.waddr (wr_ptr_q),
		.wdata ({req.right_sample, req.left_sample}),
		.re    (accept && pull_ok),
		.raddr (rd_ptr_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playback_en_q <= 1'b0;
			tone_en_q     <= 1'b0;
			tone_step_q   <= '0;
			phase_q       <= '0;
			rd_ptr_q      <= '0;
			wr_ptr_q      <= '0;
			count_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					arfm_pkg::REG_PLAYBACK_ENABLE: begin
						playback_en_q <= cfg_data[0];
					end
					arfm_pkg::REG_TONE_ENABLE: begin
						tone_en_q <= cfg_data[0];
					end
					arfm_pkg::REG_TONE_STEP: begin
						tone_step_q <= cfg_data[arfm_pkg::PHASE_W-1:0];
						phase_q     <= '0;
					end
					default: begin
					end
				endcase
			end else if (accept && mix_now) begin
				phase_q <= phase_next;
			end
			if (accept) begin
				count_q <= count_next;
				if (push_ok) begin
					wr_ptr_q <= (wr_ptr_q == arfm_pkg::PTR_W'(arfm_pkg::FIFO_FRAMES - 1)) ?
						'0 : wr_ptr_q + 1'b1;
				end
				if (pull_ok) begin
					rd_ptr_q <= (rd_ptr_q == arfm_pkg::PTR_W'(arfm_pkg::FIFO_FRAMES - 1)) ?
						'0 : rd_ptr_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1          <= status_now;
			fill_s1            <= arfm_pkg::FILL_W'(count_next);
			ctrl_s1.use_sample <= pull_ok;
			ctrl_s1.mix        <= mix_now;
			ctrl_s1.tone_pos   <= phase_next[arfm_pkg::PHASE_MSB];
		end
	end

	arfm_lane u_lane_left (
		.ctrl   (ctrl_s1),
		.sample (rdata[arfm_pkg::SAMPLE_W-1:0]),
		.mixed  (left_mix)
	);

	arfm_lane u_lane_right (
		.ctrl   (ctrl_s1),
		.sample (rdata[arfm_pkg::FRAME_W-1:arfm_pkg::SAMPLE_W]),
		.mixed  (right_mix)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			left_s2   <= left_mix;
			right_s2  <= right_mix;
			status_s2 <= status_s1;
			fill_s2   <= fill_s1;
		end
	end

	assign rsp.valid      = valid_s2;
	assign rsp.left_out   = left_s2;
	assign rsp.right_out  = right_s2;
	assign rsp.status     = status_s2;
	assign rsp.fill_level = fill_s2;

endmodule

// ===== tb/sv/arfm_mix_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arfm_mix_checker
// Watches the request, result and register ports of the playback mixer. It
// keeps its own copy of the frame ring, the phase accumulator and the
// registers, works out the mixed frame that each accepted request must give,
// and compares every accepted result field by field with the oldest one.
// ----------------------------------------------------------------------------
module arfm_mix_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	arfm_req_if                                 req,
	arfm_rsp_if                                 rsp,
	input  logic                                cfg_we,
	input  logic [arfm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [arfm_pkg::CFG_DATA_W-1:0]     cfg_data,
	output int                                  errors,
	output int                                  pending,
	output int                                  checked
);

	typedef struct packed {
		logic signed [arfm_pkg::SAMPLE_W-1:0] left;
		logic signed [arfm_pkg::SAMPLE_W-1:0] right;
		arfm_pkg::status_t                    status;
		logic [arfm_pkg::FILL_W-1:0]          fill;
	} mixed_frame_t;

	mixed_frame_t                    expected_frames [$];

	logic [arfm_pkg::FRAME_W-1:0]    frame_mem [arfm_pkg::FIFO_FRAMES];
	logic [arfm_pkg::PTR_W-1:0]      rd_ptr;
	logic [arfm_pkg::PTR_W-1:0]      wr_ptr;
	logic [arfm_pkg::CNT_W-1:0]      held;
	logic [arfm_pkg::PHASE_W-1:0]    phase_acc;
	logic [arfm_pkg::PHASE_W-1:0]    tone_inc;
	logic                            play_en;
	logic                            tone_en;

	function automatic logic [arfm_pkg::PTR_W-1:0] next_ptr(
		input logic [arfm_pkg::PTR_W-1:0] p
	);
		return (p == arfm_pkg::PTR_W'(arfm_pkg::FIFO_FRAMES - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic signed [arfm_pkg::SAMPLE_W-1:0] add_tone(
		input logic signed [arfm_pkg::SAMPLE_W-1:0] s,
		input logic                                 tone_pos
	);
		logic signed [arfm_pkg::SAMPLE_W:0] amp;
		logic signed [arfm_pkg::SAMPLE_W:0] sum;
		amp = arfm_pkg::TONE_AMP;
		if (!tone_pos) begin
			amp = -amp;
		end
		sum = s + amp;
		if (sum > arfm_pkg::SAT_MAX) begin
			return arfm_pkg::SAT_MAX;
		end else if (sum < arfm_pkg::SAT_MIN) begin
			return arfm_pkg::SAT_MIN;
		end
		return sum[arfm_pkg::SAMPLE_W-1:0];
	endfunction

	function automatic mixed_frame_t mix_request(
		input logic                          k,
		input logic [arfm_pkg::SAMPLE_W-1:0] l,
		input logic [arfm_pkg::SAMPLE_W-1:0] r
	);
		mixed_frame_t                 res;
		logic [arfm_pkg::FRAME_W-1:0] word;
		res = '0;
		res.status = arfm_pkg::ST_OK;
		if (k == arfm_pkg::KIND_PUSH) begin
			if (!play_en) begin
				res.status = arfm_pkg::ST_DISABLED;
			end else if (held >= arfm_pkg::FIFO_FRAMES) begin
				res.status = arfm_pkg::ST_FULL;
			end else begin
				frame_mem[wr_ptr] = {r, l};
				wr_ptr = next_ptr(wr_ptr);
				held = held + 1'b1;
			end
		end else begin
			if (held == 0) begin
				res.status = arfm_pkg::ST_UNDERRUN;
			end else begin
				word = frame_mem[rd_ptr];
				res.left = word[arfm_pkg::SAMPLE_W-1:0];
				res.right = word[arfm_pkg::FRAME_W-1:arfm_pkg::SAMPLE_W];
				rd_ptr = next_ptr(rd_ptr);
				held = held - 1'b1;
			end
			if (tone_en) begin
				phase_acc = phase_acc + tone_inc;
				res.left = add_tone(res.left, phase_acc[arfm_pkg::PHASE_MSB]);
				res.right = add_tone(res.right, phase_acc[arfm_pkg::PHASE_MSB]);
			end
		end
		res.fill = arfm_pkg::FILL_W'(held);
		return res;
	endfunction

	task automatic report_field(
		input string              field,
		input logic signed [31:0] want_v,
		input logic signed [31:0] got_v
	);
		if (got_v !== want_v) begin
			errors++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		mixed_frame_t want;
		if (!arst_n) begin
			expected_frames.delete();
			rd_ptr = '0;
			wr_ptr = '0;
			held = '0;
			phase_acc = '0;
			tone_inc = '0;
			play_en = 1'b0;
			tone_en = 1'b0;
			errors = 0;
			checked = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					arfm_pkg::REG_PLAYBACK_ENABLE: play_en = cfg_data[0];
					arfm_pkg::REG_TONE_ENABLE:     tone_en = cfg_data[0];
					arfm_pkg::REG_TONE_STEP: begin
						tone_inc = cfg_data;
						phase_acc = '0;
					end
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_frames.size() == 0) begin
					errors++;
					$display("%0t: result without a request: expected none, actual %0d/%0d/%0d/%0d",
						$time, rsp.left_out, rsp.right_out, rsp.status, rsp.fill_level);
				end else begin
					want = expected_frames.pop_front();
					report_field("left_out", want.left, rsp.left_out);
					report_field("right_out", want.right, rsp.right_out);
					report_field("status", {30'd0, want.status}, {30'd0, rsp.status});
					report_field("fill_level", {16'd0, want.fill}, {16'd0, rsp.fill_level});
					checked++;
				end
			end
			if (req.valid && req.ready) begin
				expected_frames.push_back(mix_request(req.kind, req.left_sample,
					req.right_sample));
			end
		end
		pending = expected_frames.size();
	end

endmodule

// ===== tb/sv/tb_audio_ring_fifo_tone_mixer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_ring_fifo_tone_mixer_top
// Drives the playback mixer with a directed opening and random phases of
// pushes and pulls under random register settings, with random gaps on the
// request and result sides.
// ----------------------------------------------------------------------------
module tb_audio_ring_fifo_tone_mixer_top;

	localparam int LATENCY         = 2;
	localparam int MAX_IDLE        = 17;
	localparam int RANDOM_REQUESTS = 530;
	localparam int PHASES          = 5;
	localparam int TIMEOUT_NS      = 1000000;
	localparam logic [arfm_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [arfm_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [arfm_pkg::CFG_DATA_W-1:0] cfg_data;

	bit src_idle_on;
	bit snk_idle_on;
	int errors;
	int pending;
	int checked;
	int pushes;
	int pulls;
	int reg_writes;

	arfm_req_if req_ch ();
	arfm_rsp_if rsp_ch ();

	audio_ring_fifo_tone_mixer_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	arfm_mix_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending),
		.checked   (checked)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [arfm_pkg::SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return arfm_pkg::SAMPLE_W'($urandom());
		endcase
	endfunction

	function automatic logic [arfm_pkg::PHASE_W-1:0] pick_step();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return 32'hffff_ffff;
			2: return 32'h8000_0000;
			3: return $urandom() >> $urandom_range(0, 31);
			default: return $urandom();
		endcase
	endfunction

	task automatic send_req(
		input logic                          k,
		input logic [arfm_pkg::SAMPLE_W-1:0] l,
		input logic [arfm_pkg::SAMPLE_W-1:0] r
	);
		int idle;
		idle = src_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
		if (idle != 0) begin
			req_ch.valid <= 1'b0;
			repeat (idle) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= k;
		req_ch.left_sample <= l;
		req_ch.right_sample <= r;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		@(negedge clk);
		if (k == arfm_pkg::KIND_PUSH) begin
			pushes++;
		end else begin
			pulls++;
		end
	endtask

	task automatic push_frame(
		input logic [arfm_pkg::SAMPLE_W-1:0] l,
		input logic [arfm_pkg::SAMPLE_W-1:0] r
	);
		send_req(arfm_pkg::KIND_PUSH, l, r);
	endtask

	task automatic pull_frame();
		send_req(arfm_pkg::KIND_PULL, arfm_pkg::SAMPLE_W'($urandom()),
			arfm_pkg::SAMPLE_W'($urandom()));
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 2) @(negedge clk);
	endtask

	task automatic write_reg(
		input logic [arfm_pkg::CFG_IDX_W-1:0]  idx,
		input logic [arfm_pkg::CFG_DATA_W-1:0] val
	);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		reg_writes++;
	endtask

	initial begin
		int idle;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			idle = snk_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
			if (idle != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (idle) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			@(negedge clk);
		end
	end

	initial begin
		int per_phase;
		int push_pct;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.kind = arfm_pkg::KIND_PUSH;
		req_ch.left_sample = '0;
		req_ch.right_sample = '0;
		src_idle_on = 1'b1;
		snk_idle_on = 1'b1;
		pushes = 0;
		pulls = 0;
		reg_writes = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Out of reset playback is off: the push is refused and the pull underruns.
		push_frame(16'h7fff, 16'h8000);
		pull_frame();
		settle();

		write_reg(arfm_pkg::REG_PLAYBACK_ENABLE, 32'd1);
		write_reg(arfm_pkg::REG_TONE_ENABLE, 32'd0);
		write_reg(arfm_pkg::REG_TONE_STEP, 32'd0);
		push_frame(16'h7fff, 16'h8000);
		push_frame(16'h8000, 16'h7fff);
		push_frame(16'h0000, 16'hffff);
		push_frame(16'hffff, 16'h0001);
		repeat (5) pull_frame();
		settle();

		// A half-turn step flips the tone sign on every pull, hitting both clamps.
		write_reg(arfm_pkg::REG_TONE_ENABLE, 32'd1);
		write_reg(arfm_pkg::REG_TONE_STEP, 32'h8000_0000);
		push_frame(16'h7fff, 16'h8000);
		push_frame(16'h8000, 16'h7fff);
		push_frame(16'h1234, 16'hedcc);
		pull_frame();
		pull_frame();
		settle();

		// Pulls are still served with playback off; pushes are refused.
		write_reg(arfm_pkg::REG_PLAYBACK_ENABLE, 32'd0);
		write_reg(REG_SPARE, 32'hffff_ffff);
		pull_frame();
		push_frame(16'h5555, 16'haaaa);
		pull_frame();
		settle();

		per_phase = RANDOM_REQUESTS / PHASES;
		for (int p = 0; p < PHASES; p++) begin
			src_idle_on = ($urandom_range(0, 3) != 0);
			snk_idle_on = ($urandom_range(0, 3) != 0);
			push_pct = $urandom_range(25, 80);
			write_reg(arfm_pkg::REG_PLAYBACK_ENABLE, {31'd0, ($urandom_range(0, 5) != 0)});
			write_reg(arfm_pkg::REG_TONE_ENABLE, {31'd0, 1'($urandom())});
			write_reg(arfm_pkg::REG_TONE_STEP, pick_step());
			for (int i = 0; i < per_phase; i++) begin
				if ($urandom_range(1, 100) <= push_pct) begin
					push_frame(pick_sample(), pick_sample());
				end else begin
					pull_frame();
				end
			end
			settle();
		end

		$display("Run covered %0d pushes, %0d pulls and %0d register writes.",
			pushes, pulls, reg_writes);
		$display("%0d results were compared against the prediction.", checked);
		if (errors == 0 && pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
